// ===== sv/dred_pkg.sv =====
// Package for the dual rotary encoder decoder: codes, reset values and shared types.
// Used by dred_result_buf, the core, dred_step_checker and tb_top; depends on nothing.
package dred_pkg;

    localparam int TIME_BITS_DEF = 32;

    localparam logic OP_EDGE = 1'b0;
    localparam logic OP_POLL = 1'b1;

    localparam logic [2:0] CH_PAIR_A   = 3'd0;
    localparam logic [2:0] CH_PAIR_B   = 3'd1;
    localparam logic [2:0] CH_ENTER    = 3'd2;
    localparam logic [2:0] CH_SCROLL_A = 3'd3;
    localparam logic [2:0] CH_SCROLL_B = 3'd4;
    localparam logic [2:0] CH_BACK     = 3'd5;

    localparam logic [2:0] KIND_SCROLL_A = 3'd0;
    localparam logic [2:0] KIND_SCROLL_B = 3'd1;
    localparam logic [2:0] KIND_PAIR_A   = 3'd2;
    localparam logic [2:0] KIND_PAIR_B   = 3'd3;
    localparam logic [2:0] KIND_ENTER    = 3'd4;
    localparam logic [2:0] KIND_BACK     = 3'd5;

    localparam logic [1:0] REG_SUSPENDED = 2'd0;
    localparam logic [1:0] REG_GUARD_MS  = 2'd1;
    localparam logic [1:0] REG_STALE_MS  = 2'd2;

    localparam logic [15:0] GUARD_MS_RST = 16'd50;
    localparam logic [15:0] STALE_MS_RST = 16'd100;

    // start flag slots
    localparam int SLOT_SCROLL_A = 0;
    localparam int SLOT_SCROLL_B = 1;
    localparam int SLOT_PAIR_A   = 2;
    localparam int SLOT_PAIR_B   = 3;

    // step end slots
    localparam int END_SCROLL = 0;
    localparam int END_PAIR   = 1;

    typedef struct packed {
        logic [1:0] cnt;
        logic [2:0] kind0;
        logic [2:0] kind1;
    } t_res_pair;

endpackage

// ===== sv/dred_result_buf.sv =====
// Two-entry result register: takes up to two results per item, hands them out one per transfer.
// Depends on dred_pkg (t_res_pair).
module dred_result_buf (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_load,
    input  dred_pkg::t_res_pair i_pair,
    output logic                o_free,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic [2:0]          o_event_kind,
    output logic                o_last_of_run
);

    logic [1:0] r_cnt;
    logic [2:0] r_kind0;
    logic [2:0] r_kind1;
    logic       w_xfer;

    assign w_xfer        = (r_cnt != 2'd0) && i_out_ready;
    assign o_free        = (r_cnt == 2'd0) || ((r_cnt == 2'd1) && i_out_ready);
    assign o_out_valid   = (r_cnt != 2'd0);
    assign o_event_kind  = r_kind0;
    assign o_last_of_run = (r_cnt == 2'd1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else if (i_load) begin
            r_cnt <= i_pair.cnt;
        end else if (w_xfer) begin
            r_cnt <= r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_kind0 <= i_pair.kind0;
            r_kind1 <= i_pair.kind1;
        end else if (w_xfer) begin
            r_kind0 <= r_kind1;
        end
    end

endmodule

// ===== sv/dual_rotary_encoder_decoder_core.sv =====
// Top level of the dual rotary encoder decoder: input register, step decode and state.
// Depends on dred_pkg and dred_result_buf.
//
// Usage:
//   Input channel (i_in_valid / o_in_ready) carries one event per transfer: an edge
//   event (op 0) with its channel, or a key poll (op 1); each carries sampled pin
//   levels and a millisecond timestamp.
//   Output channel (o_out_valid / i_out_ready) carries result items; o_last_of_run
//   marks the final result of an event. Edge events give zero or one result, polls
//   give zero to two (enter before back).
//   An event passes through the input register and then the result register.
//   Throughput: one event per cycle while the receiver is ready; a poll with two
//   results holds the result register for two transfers, and the next event waits.
//   Config writes (i_cfg_wr_en, i_cfg_index, i_cfg_wdata) take effect at once; the
//   user must make them while the block is idle, as the block does not enforce it.
//   Reset (synchronous, active low) clears start flags, timestamps, step history
//   and both pipeline registers; guard is 50 ms and stale 100 ms after reset.
//   When the receiver stalls, results hold in the result register and the input
//   register fills, after which o_in_ready drops.
module dual_rotary_encoder_decoder_core #(
    parameter int TIME_BITS = dred_pkg::TIME_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_wdata,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_op,
    input  logic [2:0]  i_channel,
    input  logic [5:0]  i_pin_levels,
    input  logic [31:0] i_now_ms,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [2:0]  o_event_kind,
    output logic        o_last_of_run
);

    logic                 r_suspended;
    logic [15:0]          r_guard_ms;
    logic [15:0]          r_stale_ms;

    logic                 r_s1_valid;
    logic                 r_op;
    logic [2:0]           r_ch;
    logic [5:0]           r_pins;
    logic [TIME_BITS-1:0] r_now;

    logic [3:0]           r_flag;
    logic [TIME_BITS-1:0] r_start_t [4];
    logic [TIME_BITS-1:0] r_end_t [2];
    logic [1:0]           r_end_valid;

    logic [3:0]           n_flag;
    logic [TIME_BITS-1:0] n_start_t [4];
    logic [TIME_BITS-1:0] n_end_t [2];
    logic [1:0]           n_end_valid;
    dred_pkg::t_res_pair  n_pair;

    logic                 w_free;
    logic                 w_s1_adv;
    logic [TIME_BITS-1:0] w_guard;
    logic [TIME_BITS-1:0] w_stale;
    logic [TIME_BITS-1:0] w_age_start [4];
    logic [TIME_BITS-1:0] w_age_end [2];
    logic [1:0]           w_guarded;
    logic                 w_own_pin;
    logic                 w_ch_ok;
    logic                 w_edge_go;
    logic                 p0, p1, p3, p4;

    assign w_s1_adv   = r_s1_valid && w_free;
    assign o_in_ready = !r_s1_valid || w_free;

    // config
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_suspended <= 1'b0;
            r_guard_ms  <= dred_pkg::GUARD_MS_RST;
            r_stale_ms  <= dred_pkg::STALE_MS_RST;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                dred_pkg::REG_SUSPENDED: r_suspended <= i_cfg_wdata[0];
                dred_pkg::REG_GUARD_MS:  r_guard_ms  <= i_cfg_wdata;
                dred_pkg::REG_STALE_MS:  r_stale_ms  <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_s1_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_op   <= i_op;
            r_ch   <= i_channel;
            r_pins <= i_pin_levels;
            r_now  <= TIME_BITS'(i_now_ms);
        end
    end

    assign w_guard = TIME_BITS'(r_guard_ms);
    assign w_stale = TIME_BITS'(r_stale_ms);

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            w_age_start[k] = r_now - r_start_t[k];
        end
        for (int k = 0; k < 2; k++) begin
            w_age_end[k] = r_now - r_end_t[k];
            w_guarded[k] = r_end_valid[k] && (w_age_end[k] < w_guard);
        end
    end

    assign p0 = r_pins[0];
    assign p1 = r_pins[1];
    assign p3 = r_pins[3];
    assign p4 = r_pins[4];

    always_comb begin
        w_ch_ok   = 1'b1;
        w_own_pin = 1'b1;
        unique case (r_ch)
            dred_pkg::CH_PAIR_A,
            dred_pkg::CH_PAIR_B:   begin
                w_own_pin = r_pins[r_ch];
                w_ch_ok   = !w_guarded[dred_pkg::END_PAIR];
            end
            dred_pkg::CH_SCROLL_A,
            dred_pkg::CH_SCROLL_B: begin
                w_own_pin = r_pins[r_ch];
                w_ch_ok   = !w_guarded[dred_pkg::END_SCROLL];
            end
            dred_pkg::CH_ENTER,
            dred_pkg::CH_BACK:     w_own_pin = r_pins[r_ch];
            default:               w_ch_ok = 1'b0;
        endcase
    end

    assign w_edge_go = (r_op == dred_pkg::OP_EDGE) && !r_suspended && w_ch_ok && !w_own_pin;

    // step and key poll decode
    always_comb begin
        n_flag      = r_flag;
        n_start_t   = r_start_t;
        n_end_t     = r_end_t;
        n_end_valid = r_end_valid;
        n_pair      = '{cnt: 2'd0, kind0: dred_pkg::KIND_ENTER, kind1: dred_pkg::KIND_BACK};

        if (r_op == dred_pkg::OP_POLL) begin
            if (!r_pins[2] && !r_pins[5]) begin
                n_pair.cnt = 2'd2;
            end else if (!r_pins[2]) begin
                n_pair.cnt = 2'd1;
            end else if (!r_pins[5]) begin
                n_pair.cnt   = 2'd1;
                n_pair.kind0 = dred_pkg::KIND_BACK;
            end
        end else if (w_edge_go) begin
            for (int k = 0; k < 4; k++) begin
                if (w_age_start[k] > w_stale) begin
                    n_flag[k] = 1'b0;
                end
            end
            case (r_ch)
                dred_pkg::CH_SCROLL_A: begin
                    if (n_flag[dred_pkg::SLOT_SCROLL_B]) begin
                        if (!p3 && !p4) begin
                            n_flag[dred_pkg::SLOT_SCROLL_A]  = 1'b0;
                            n_flag[dred_pkg::SLOT_SCROLL_B]  = 1'b0;
                            n_end_t[dred_pkg::END_SCROLL]     = r_now;
                            n_end_valid[dred_pkg::END_SCROLL] = 1'b1;
                            n_pair.cnt   = 2'd1;
                            n_pair.kind0 = dred_pkg::KIND_SCROLL_A;
                        end
                    end else if (!p3 && p4) begin
                        n_flag[dred_pkg::SLOT_SCROLL_A]    = 1'b1;
                        n_start_t[dred_pkg::SLOT_SCROLL_A] = r_now;
                    end
                end
                dred_pkg::CH_SCROLL_B: begin
                    if (n_flag[dred_pkg::SLOT_SCROLL_A]) begin
                        if (!p3 && !p4) begin
                            n_flag[dred_pkg::SLOT_SCROLL_A]  = 1'b0;
                            n_flag[dred_pkg::SLOT_SCROLL_B]  = 1'b0;
                            n_end_t[dred_pkg::END_SCROLL]     = r_now;
                            n_end_valid[dred_pkg::END_SCROLL] = 1'b1;
                            n_pair.cnt   = 2'd1;
                            n_pair.kind0 = dred_pkg::KIND_SCROLL_B;
                        end
                    end else if (!p4 && p3) begin
                        n_flag[dred_pkg::SLOT_SCROLL_B]    = 1'b1;
                        n_start_t[dred_pkg::SLOT_SCROLL_B] = r_now;
                    end
                end
                dred_pkg::CH_PAIR_A: begin
                    if (n_flag[dred_pkg::SLOT_PAIR_B]) begin
                        if (!p0 && !p1) begin
                            n_flag[dred_pkg::SLOT_PAIR_A]  = 1'b0;
                            n_flag[dred_pkg::SLOT_PAIR_B]  = 1'b0;
                            n_end_t[dred_pkg::END_PAIR]     = r_now;
                            n_end_valid[dred_pkg::END_PAIR] = 1'b1;
                            n_pair.cnt   = 2'd1;
                            n_pair.kind0 = dred_pkg::KIND_PAIR_A;
                        end
                    end else if (!p0 && p1) begin
                        n_flag[dred_pkg::SLOT_PAIR_A]    = 1'b1;
                        n_start_t[dred_pkg::SLOT_PAIR_A] = r_now;
                    end
                end
                dred_pkg::CH_PAIR_B: begin
                    if (n_flag[dred_pkg::SLOT_PAIR_A]) begin
                        if (!p0 && !p1) begin
                            n_flag[dred_pkg::SLOT_PAIR_A]  = 1'b0;
                            n_flag[dred_pkg::SLOT_PAIR_B]  = 1'b0;
                            n_end_t[dred_pkg::END_PAIR]     = r_now;
                            n_end_valid[dred_pkg::END_PAIR] = 1'b1;
                            n_pair.cnt   = 2'd1;
                            n_pair.kind0 = dred_pkg::KIND_PAIR_B;
                        end
                    end else if (!p1 && p0) begin
                        n_flag[dred_pkg::SLOT_PAIR_B]    = 1'b1;
                        n_start_t[dred_pkg::SLOT_PAIR_B] = r_now;
                    end
                end
                default: ;
            endcase
        end
    end

    // decoder state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flag      <= '0;
            r_end_valid <= '0;
            for (int k = 0; k < 4; k++) begin
                r_start_t[k] <= '0;
            end
            for (int k = 0; k < 2; k++) begin
                r_end_t[k] <= '0;
            end
        end else if (w_s1_adv) begin
            r_flag      <= n_flag;
            r_start_t   <= n_start_t;
            r_end_t     <= n_end_t;
            r_end_valid <= n_end_valid;
        end
    end

    dred_result_buf u_result_buf (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_load        (w_s1_adv),
        .i_pair        (n_pair),
        .o_free        (w_free),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_event_kind  (o_event_kind),
        .o_last_of_run (o_last_of_run)
    );

endmodule

// ===== tb/sv/dred_step_checker.sv =====
// Checker for the dual rotary encoder decoder: watches the config port and both channels,
// predicts the decoded events of every input transfer and compares each output transfer.
// Depends on dred_pkg.
module dred_step_checker
    import dred_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_wdata,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic        i_op,
    input  logic [2:0]  i_channel,
    input  logic [5:0]  i_pin_levels,
    input  logic [31:0] i_now_ms,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [2:0]  i_event_kind,
    input  logic        i_last_of_run,
    output int          o_pending,
    output int          o_errors,
    output int          o_results
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [2:0] kind;
        logic       last;
    } t_decoded;

    t_decoded events_due[$];

    logic        sus;
    logic [15:0] guard;
    logic [15:0] stale;
    logic [3:0]  armed;
    logic [31:0] arm_time [4];
    logic [31:0] step_time [2];
    logic [1:0]  step_seen;
    int          errors;
    int          results;

    function automatic void decode_event(input logic op, input logic [2:0] ch,
                                         input logic [5:0] pins, input logic [31:0] now);
        logic [2:0]  kinds [2];
        logic [2:0]  kind;
        logic [2:0]  mate_ch;
        logic [31:0] age;
        bit          pair_ch;
        int          n;
        int          s;
        int          slot_own;
        int          slot_mate;
        int          grp;
        n         = 0;
        pair_ch   = 1'b1;
        slot_own  = SLOT_SCROLL_A;
        slot_mate = SLOT_SCROLL_B;
        grp       = END_SCROLL;
        kind      = KIND_SCROLL_A;
        mate_ch   = CH_SCROLL_B;
        case (ch)
            CH_SCROLL_A: begin
                slot_own = SLOT_SCROLL_A; slot_mate = SLOT_SCROLL_B; mate_ch = CH_SCROLL_B;
                grp = END_SCROLL; kind = KIND_SCROLL_A;
            end
            CH_SCROLL_B: begin
                slot_own = SLOT_SCROLL_B; slot_mate = SLOT_SCROLL_A; mate_ch = CH_SCROLL_A;
                grp = END_SCROLL; kind = KIND_SCROLL_B;
            end
            CH_PAIR_A: begin
                slot_own = SLOT_PAIR_A; slot_mate = SLOT_PAIR_B; mate_ch = CH_PAIR_B;
                grp = END_PAIR; kind = KIND_PAIR_A;
            end
            CH_PAIR_B: begin
                slot_own = SLOT_PAIR_B; slot_mate = SLOT_PAIR_A; mate_ch = CH_PAIR_A;
                grp = END_PAIR; kind = KIND_PAIR_B;
            end
            default: pair_ch = 1'b0;
        endcase

        if (op == OP_POLL) begin
            if (!pins[2]) begin
                kinds[n] = KIND_ENTER;
                n++;
            end
            if (!pins[5]) begin
                kinds[n] = KIND_BACK;
                n++;
            end
        end else if (!sus && ch <= CH_BACK && !pins[ch]) begin
            age = now - step_time[grp];
            if (!pair_ch || !step_seen[grp] || age >= {16'd0, guard}) begin
                for (s = 0; s < 4; s++) begin
                    age = now - arm_time[s];
                    if (age > {16'd0, stale}) armed[s] = 1'b0;
                end
                if (pair_ch) begin
                    if (armed[slot_mate]) begin
                        if (!pins[mate_ch]) begin
                            step_time[grp]  = now;
                            step_seen[grp]  = 1'b1;
                            armed[slot_own]  = 1'b0;
                            armed[slot_mate] = 1'b0;
                            kinds[n] = kind;
                            n++;
                        end
                    end else if (pins[mate_ch]) begin
                        arm_time[slot_own] = now;
                        armed[slot_own]    = 1'b1;
                    end
                end
            end
        end

        for (s = 0; s < n; s++) events_due.push_back('{kind: kinds[s], last: (s == n - 1)});
    endfunction

    always @(posedge i_clk) begin
        t_decoded want;
        if (!i_rst_n) begin
            sus       = 1'b0;
            guard     = GUARD_MS_RST;
            stale     = STALE_MS_RST;
            armed     = '0;
            step_seen = '0;
            for (int k = 0; k < 4; k++) arm_time[k] = '0;
            for (int k = 0; k < 2; k++) step_time[k] = '0;
            events_due.delete();
            errors  = 0;
            results = 0;
        end else begin
            if (i_out_valid && i_out_ready) begin
                results++;
                if (events_due.size() == 0) begin
                    $error("result with nothing expected: event_kind %0d last_of_run %0d",
                           i_event_kind, i_last_of_run);
                    errors++;
                end else begin
                    want = events_due.pop_front();
                    if (i_event_kind !== want.kind) begin
                        $error("event_kind mismatch: expected %0d, got %0d",
                               want.kind, i_event_kind);
                        errors++;
                    end
                    if (i_last_of_run !== want.last) begin
                        $error("last_of_run mismatch: expected %0d, got %0d",
                               want.last, i_last_of_run);
                        errors++;
                    end
                end
            end
            if (i_cfg_wr_en) begin
                case (i_cfg_index)
                    REG_SUSPENDED: sus   = i_cfg_wdata[0];
                    REG_GUARD_MS:  guard = i_cfg_wdata;
                    REG_STALE_MS:  stale = i_cfg_wdata;
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready)
                decode_event(i_op, i_channel, i_pin_levels, i_now_ms);
        end
        o_pending <= events_due.size();
        o_errors  <= errors;
        o_results <= results;
    end

endmodule

// ===== tb/sv/tb_top.sv =====
// Testbench top for dual_rotary_encoder_decoder_core: clock, reset, directed and random
// encoder/key traffic, register phases and the verdict. Depends on dred_pkg,
// dred_step_checker and the core.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import dred_pkg::*;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_wr_en;
    logic [1:0]  i_cfg_index;
    logic [15:0] i_cfg_wdata;
    logic        i_in_valid;
    logic        o_in_ready;
    logic        i_op;
    logic [2:0]  i_channel;
    logic [5:0]  i_pin_levels;
    logic [31:0] i_now_ms;
    logic        o_out_valid;
    logic        i_out_ready;
    logic [2:0]  o_event_kind;
    logic        o_last_of_run;

    int pending;
    int errors;
    int results;

    logic [31:0] clock_ms;
    int          cur_guard;
    int          cur_stale;
    int          sent;
    int          idle_pct;
    int          settings;
    bit          idle_en;

    dual_rotary_encoder_decoder_core uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_op          (i_op),
        .i_channel     (i_channel),
        .i_pin_levels  (i_pin_levels),
        .i_now_ms      (i_now_ms),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_event_kind  (o_event_kind),
        .o_last_of_run (o_last_of_run)
    );

    dred_step_checker chk (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_in_valid    (i_in_valid),
        .i_in_ready    (o_in_ready),
        .i_op          (i_op),
        .i_channel     (i_channel),
        .i_pin_levels  (i_pin_levels),
        .i_now_ms      (i_now_ms),
        .i_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .i_event_kind  (o_event_kind),
        .i_last_of_run (o_last_of_run),
        .o_pending     (pending),
        .o_errors      (errors),
        .o_results     (results)
    );

    initial i_clk = 1'b0;
    always #10 i_clk = ~i_clk;

    initial begin
        #20_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    // receiver: ready in runs, stalls in bursts while idling is allowed
    initial begin
        i_out_ready = 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            if (idle_en && $urandom_range(0, 99) < 30) begin
                i_out_ready <= 1'b0;
                repeat ($urandom_range(1, 18)) @(posedge i_clk);
            end else begin
                i_out_ready <= 1'b1;
                repeat ($urandom_range(1, 25)) @(posedge i_clk);
            end
        end
    end

    task automatic send(input logic op, input logic [2:0] ch, input logic [5:0] pins,
                        input logic [31:0] now);
        if (idle_en && $urandom_range(0, 99) < idle_pct) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_op         <= op;
        i_channel    <= ch;
        i_pin_levels <= pins;
        i_now_ms     <= now;
        do @(posedge i_clk); while (!o_in_ready);
        sent++;
        if (sent % 40 == 0) begin
            case ($urandom_range(0, 2))
                0: idle_pct = 0;
                1: idle_pct = 10;
                default: idle_pct = 35;
            endcase
        end
    endtask

    task automatic fall(input logic [2:0] ch, input logic [5:0] pins);
        send(OP_EDGE, ch, pins, clock_ms);
    endtask

    task automatic tick(input logic [5:0] pins);
        send(OP_POLL, 3'($urandom_range(0, 7)), pins, clock_ms);
    endtask

    // hold off new transfers until every expected result is out, then let the pipe empty
    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_regs(input logic susp, input logic [15:0] guard,
                              input logic [15:0] stale);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= REG_SUSPENDED;
        i_cfg_wdata <= {15'($urandom), susp};
        @(posedge i_clk);
        i_cfg_index <= REG_GUARD_MS;
        i_cfg_wdata <= guard;
        @(posedge i_clk);
        i_cfg_index <= REG_STALE_MS;
        i_cfg_wdata <= stale;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        cur_guard = int'(guard);
        cur_stale = int'(stale);
        settings++;
    endtask

    // arm one channel of a pair, then finish the step on its partner
    task automatic spin_step(input bit scroll);
        logic [2:0] own;
        logic [2:0] mate;
        logic [5:0] pins;
        own  = scroll ? CH_SCROLL_A : CH_PAIR_A;
        mate = scroll ? CH_SCROLL_B : CH_PAIR_B;
        if ($urandom_range(0, 1)) begin
            own  = mate;
            mate = scroll ? CH_SCROLL_A : CH_PAIR_A;
        end
        case ($urandom_range(0, 9))
            0: clock_ms += (cur_guard > 0) ? cur_guard - 1 : 0;
            1: clock_ms += cur_guard;
            2, 3: clock_ms += $urandom_range(0, cur_guard);
            default: clock_ms += cur_guard + $urandom_range(0, 30);
        endcase
        pins = 6'($urandom);
        pins[own]  = 1'b0;
        pins[mate] = 1'b1;
        fall(own, pins);
        if ($urandom_range(0, 4) == 0) begin
            clock_ms += $urandom_range(0, 3);
            pins = 6'($urandom);
            pins[mate] = 1'b0;
            pins[own]  = 1'b1;
            fall(mate, pins);
        end
        case ($urandom_range(0, 9))
            0: clock_ms += cur_stale;
            1: clock_ms += cur_stale + 1;
            2: clock_ms += cur_stale + $urandom_range(2, 500);
            default: clock_ms += $urandom_range(0, cur_stale);
        endcase
        pins = 6'($urandom);
        pins[own]  = 1'b0;
        pins[mate] = 1'b0;
        fall(mate, pins);
    endtask

    task automatic noise();
        if ($urandom_range(0, 19) == 0) clock_ms = $urandom;
        else clock_ms += $urandom_range(0, 200);
        send(($urandom_range(0, 3) == 0) ? OP_POLL : OP_EDGE, 3'($urandom_range(0, 7)),
             6'($urandom), clock_ms);
    endtask

    task automatic run_phase(input int count);
        int stop;
        int r;
        stop = sent + count;
        while (sent < stop) begin
            r = $urandom_range(0, 99);
            if (r < 55) spin_step(1'($urandom_range(0, 1)));
            else if (r < 75) tick(6'($urandom));
            else noise();
        end
    endtask

    initial begin
        i_rst_n      = 1'b0;
        i_cfg_wr_en  = 1'b0;
        i_cfg_index  = REG_SUSPENDED;
        i_cfg_wdata  = '0;
        i_in_valid   = 1'b0;
        i_op         = OP_EDGE;
        i_channel    = CH_PAIR_A;
        i_pin_levels = '1;
        i_now_ms     = '0;
        clock_ms     = 32'd1000;
        cur_guard    = int'(GUARD_MS_RST);
        cur_stale    = int'(STALE_MS_RST);
        sent         = 0;
        settings     = 1;
        idle_pct     = 20;
        idle_en      = 1'b1;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // keys
        tick(6'b000000);
        tick(6'b111111);
        tick(6'b111011);
        tick(6'b011111);
        // unknown channels and a pin that reads high
        fall(3'd6, 6'b000000);
        fall(3'd7, 6'b000000);
        fall(CH_SCROLL_A, 6'b001000);
        // scroll step, guard, armed without both low, reverse step
        fall(CH_SCROLL_A, 6'b010000);
        clock_ms = 32'd1010; fall(CH_SCROLL_B, 6'b000000);
        clock_ms = 32'd1020; fall(CH_SCROLL_A, 6'b010000);
        clock_ms = 32'd1100; fall(CH_SCROLL_B, 6'b001000);
        clock_ms = 32'd1105; fall(CH_SCROLL_A, 6'b010000);
        clock_ms = 32'd1110; fall(CH_SCROLL_A, 6'b000000);
        // second pair both ways, then a stale start flag
        clock_ms = 32'd1200; fall(CH_PAIR_A, 6'b000010);
        clock_ms = 32'd1210; fall(CH_PAIR_B, 6'b000000);
        clock_ms = 32'd1300; fall(CH_PAIR_B, 6'b000001);
        clock_ms = 32'd1320; fall(CH_PAIR_A, 6'b000000);
        clock_ms = 32'd1400; fall(CH_PAIR_A, 6'b000010);
        clock_ms = 32'd1501; fall(CH_PAIR_B, 6'b000000);
        // key channel edges
        clock_ms = 32'd1510; fall(CH_ENTER, 6'b000000);
        fall(CH_BACK, 6'b000000);
        tick(6'b000000);

        run_phase(130);
        drain();
        write_regs(1'b0, 16'd0, 16'd0);
        run_phase(130);
        drain();
        write_regs(1'b0, 16'hFFFF, 16'hFFFF);
        run_phase(130);
        drain();
        write_regs(1'b1, 16'($urandom), 16'($urandom));
        run_phase(110);
        drain();
        write_regs(1'b0, 16'hFFFF, 16'd0);
        run_phase(110);
        drain();
        clock_ms = 32'hFFFF_F000;
        write_regs(1'b0, 16'($urandom_range(0, 300)), 16'($urandom_range(0, 300)));
        run_phase(150);
        drain();
        idle_en = 1'b0;
        write_regs(1'b0, 16'd30, 16'd120);
        run_phase(150);

        drain();
        repeat (8) @(posedge i_clk);
        $display("Ran %0d events (polls, edges on every channel, steps on both encoders)",
                 sent);
        $display("over %0d register settings with stalls on both sides; %0d results checked.",
                 settings, results);
        if (errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
